// ----- sv/tgarle_pkg.sv -----
`default_nettype none
package tgarle_pkg;

  localparam int unsigned HdrIdxW = 5;

  localparam logic [HdrIdxW-1:0] HDR_ID_LEN  = 5'd0;
  localparam logic [HdrIdxW-1:0] HDR_TYPE    = 5'd2;
  localparam logic [HdrIdxW-1:0] HDR_WIDTH_L = 5'd12;
  localparam logic [HdrIdxW-1:0] HDR_WIDTH_H = 5'd13;
  localparam logic [HdrIdxW-1:0] HDR_HGHT_L  = 5'd14;
  localparam logic [HdrIdxW-1:0] HDR_HGHT_H  = 5'd15;
  localparam logic [HdrIdxW-1:0] HDR_DEPTH   = 5'd16;
  localparam logic [HdrIdxW-1:0] HDR_LAST    = 5'd17;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;

  localparam logic [4:0] BPP_RGB  = 5'd3;
  localparam logic [4:0] BPP_RGBA = 5'd4;

  localparam logic [7:0] RUN_FLAG_MIN = 8'd128;
  localparam logic [7:0] RUN_BIAS     = 8'd127;

  typedef enum logic [2:0] {
    PH_DONE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_IDSKIP = 3'd2,
    PH_PACKET = 3'd3,
    PH_PIXEL  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_PIXEL     = 2'd1,
    KIND_BAD_TYPE  = 2'd2,
    KIND_BAD_DEPTH = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_of_file;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic        last_of_image;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/tgarle_in_reg.sv -----
`default_nettype none
module tgarle_in_reg (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          byte_value,
  input  wire                 first_of_file,
  input  wire                 advance,
  output logic                stg_valid,
  output tgarle_pkg::in_t     stg
);
  import tgarle_pkg::*;

  logic take;

  assign in_ready = !stg_valid || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (take) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg.byte_value    <= byte_value;
      stg.first_of_file <= first_of_file;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tgarle_core.sv -----
`default_nettype none
module tgarle_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 stg_valid,
  input  tgarle_pkg::in_t     stg,
  input  wire                 advance,
  output logic                res_valid,
  output tgarle_pkg::res_t    res
);
  import tgarle_pkg::*;

  phase_t              phase, phase_next;
  logic [HdrIdxW-1:0]  header_index, header_index_next;
  logic [7:0]          image_type, image_type_next;
  logic [7:0]          id_length_left, id_length_left_next;
  logic [15:0]         width_reg, width_reg_next;
  logic [15:0]         height_reg, height_reg_next;
  logic                four_bytes, four_bytes_next;
  logic [31:0]         pixels_left, pixels_left_next;
  logic [7:0]          packet_left, packet_left_next;
  logic [1:0]          byte_in_pixel, byte_in_pixel_next;
  logic                run_packet, run_packet_next;
  logic [23:0]         pixel_bytes, pixel_bytes_next;

  phase_t              cur_phase;
  logic [HdrIdxW-1:0]  cur_idx;
  logic [7:0]          b;
  logic [4:0]          bpp;
  logic [31:0]         area;
  logic [1:0]          last_pos;
  logic [7:0]          count;
  logic [31:0]         pixels_after;
  logic                run_short;
  logic                step;

  assign step = stg_valid && advance;
  assign b    = stg.byte_value;
  assign bpp  = pixel_bytes[7:3];
  assign area = {16'd0, width_reg} * {16'd0, height_reg};

  // a restart byte is always header byte 0
  assign cur_phase = stg.first_of_file ? PH_HEADER : phase;
  assign cur_idx   = stg.first_of_file ? '0 : header_index;

  assign last_pos     = four_bytes ? 2'd3 : 2'd2;
  assign run_short    = {24'd0, packet_left} < pixels_left;
  assign count        = !run_packet ? 8'd1 : (run_short ? packet_left : pixels_left[7:0]);
  assign pixels_after = pixels_left - {24'd0, count};

  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    image_type_next     = image_type;
    id_length_left_next = id_length_left;
    width_reg_next      = width_reg;
    height_reg_next     = height_reg;
    four_bytes_next     = four_bytes;
    pixels_left_next    = pixels_left;
    packet_left_next    = packet_left;
    byte_in_pixel_next  = byte_in_pixel;
    run_packet_next     = run_packet;
    pixel_bytes_next    = pixel_bytes;
    res_valid           = 1'b0;
    res                 = '0;

    case (cur_phase)
      PH_HEADER: begin
        phase_next        = PH_HEADER;
        header_index_next = cur_idx + 5'd1;
        case (cur_idx)
          HDR_ID_LEN:  id_length_left_next = b;
          HDR_TYPE:    image_type_next     = b;
          HDR_WIDTH_L: width_reg_next      = {width_reg[15:8], b};
          HDR_WIDTH_H: width_reg_next      = {b, width_reg[7:0]};
          HDR_HGHT_L:  height_reg_next     = {height_reg[15:8], b};
          HDR_HGHT_H:  height_reg_next     = {b, height_reg[7:0]};
          HDR_DEPTH:   pixel_bytes_next    = {16'd0, b};
          default: ;
        endcase
        if (cur_idx == HDR_LAST) begin
          res_valid          = 1'b1;
          res.image_width    = width_reg;
          res.image_height   = height_reg;
          if (image_type != TYPE_RAW && image_type != TYPE_RLE) begin
            phase_next = PH_DONE;
            res.kind   = KIND_BAD_TYPE;
          end else if (bpp != BPP_RGB && bpp != BPP_RGBA) begin
            phase_next = PH_DONE;
            res.kind   = KIND_BAD_DEPTH;
          end else begin
            four_bytes_next = (bpp == BPP_RGBA);
            pixels_left_next = area;
            res.kind      = KIND_HEADER;
            res.has_alpha = (bpp == BPP_RGBA);
            if (width_reg == 16'd0 || height_reg == 16'd0) begin
              phase_next        = PH_DONE;
              res.last_of_image = 1'b1;
            end else if (id_length_left != 8'd0) begin
              phase_next = PH_IDSKIP;
            end else begin
              byte_in_pixel_next = '0;
              pixel_bytes_next   = '0;
              if (image_type == TYPE_RLE) begin
                phase_next = PH_PACKET;
              end else begin
                phase_next       = PH_PIXEL;
                run_packet_next  = 1'b0;
                packet_left_next = 8'd1;
              end
            end
          end
        end
      end
      PH_IDSKIP: begin
        id_length_left_next = id_length_left - 8'd1;
        if (id_length_left == 8'd1) begin
          byte_in_pixel_next = '0;
          pixel_bytes_next   = '0;
          if (image_type == TYPE_RLE) begin
            phase_next = PH_PACKET;
          end else begin
            phase_next       = PH_PIXEL;
            run_packet_next  = 1'b0;
            packet_left_next = 8'd1;
          end
        end
      end
      PH_PACKET: begin
        if (b < RUN_FLAG_MIN) begin
          run_packet_next  = 1'b0;
          packet_left_next = b + 8'd1;
        end else begin
          run_packet_next  = 1'b1;
          packet_left_next = b - RUN_BIAS;
        end
        byte_in_pixel_next = '0;
        pixel_bytes_next   = '0;
        phase_next         = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (byte_in_pixel < last_pos) begin
          case (byte_in_pixel)
            2'd0:    pixel_bytes_next = pixel_bytes | {16'd0, b};
            2'd1:    pixel_bytes_next = pixel_bytes | {8'd0, b, 8'd0};
            default: pixel_bytes_next = pixel_bytes | {b, 16'd0};
          endcase
          byte_in_pixel_next = byte_in_pixel + 2'd1;
        end else begin
          res_valid         = 1'b1;
          res.kind          = KIND_PIXEL;
          res.has_alpha     = four_bytes;
          res.blue          = pixel_bytes[7:0];
          res.green         = pixel_bytes[15:8];
          res.red           = four_bytes ? pixel_bytes[23:16] : b;
          res.alpha         = four_bytes ? b : 8'd0;
          res.repeat_count  = count;
          res.last_of_image = (pixels_after == 32'd0);
          byte_in_pixel_next = '0;
          pixel_bytes_next   = '0;
          pixels_left_next   = pixels_after;
          packet_left_next   = run_packet ? 8'd0 : packet_left - 8'd1;
          if (pixels_after == 32'd0) begin
            phase_next = PH_DONE;
          end else if (image_type == TYPE_RLE) begin
            if (run_packet || packet_left == 8'd1) begin
              phase_next = PH_PACKET;
            end
          end else begin
            packet_left_next = 8'd1;
          end
        end
      end
      default: ;
    endcase

    if (!stg_valid) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DONE;
      header_index   <= '0;
      image_type     <= '0;
      id_length_left <= '0;
      width_reg      <= '0;
      height_reg     <= '0;
      four_bytes     <= 1'b0;
      pixels_left    <= '0;
      packet_left    <= '0;
      byte_in_pixel  <= '0;
      run_packet     <= 1'b0;
      pixel_bytes    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      image_type     <= image_type_next;
      id_length_left <= id_length_left_next;
      width_reg      <= width_reg_next;
      height_reg     <= height_reg_next;
      four_bytes     <= four_bytes_next;
      pixels_left    <= pixels_left_next;
      packet_left    <= packet_left_next;
      byte_in_pixel  <= byte_in_pixel_next;
      run_packet     <= run_packet_next;
      pixel_bytes    <= pixel_bytes_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tgarle_out_reg.sv -----
`default_nettype none
module tgarle_out_reg (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 res_valid,
  input  tgarle_pkg::res_t    res,
  output logic                advance,
  output logic                out_valid,
  input  wire                 out_ready,
  output tgarle_pkg::res_t    out_res
);
  import tgarle_pkg::*;

  logic load;

  // the stage moves whenever the result slot is free or being emptied
  assign advance = !out_valid || out_ready;
  assign load    = res_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tga_rle_image_decoder.sv -----
// an accepted byte is held in the input register; its result is loaded into the output register when advance is high
// throughput: one byte per cycle while out_ready stays high
// a byte that makes no result still passes through the input stage
// rate is set by the single combinational decode step between input and result registers
// reset: synchronous active-high rst; parser waits for a byte with first_of_file set
`default_nettype none
module tga_rle_image_decoder (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  byte_value,
  input  wire         first_of_file,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  kind,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic        has_alpha,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [7:0]  repeat_count,
  output logic        last_of_image
);
  import tgarle_pkg::*;

  logic advance;
  logic stg_valid;
  in_t  stg;
  logic res_valid;
  res_t res;
  res_t out_res;

  tgarle_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_value   (byte_value),
    .first_of_file(first_of_file),
    .advance      (advance),
    .stg_valid    (stg_valid),
    .stg          (stg)
  );

  tgarle_core u_core (
    .clk      (clk),
    .rst      (rst),
    .stg_valid(stg_valid),
    .stg      (stg),
    .advance  (advance),
    .res_valid(res_valid),
    .res      (res)
  );

  tgarle_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .advance  (advance),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign kind          = out_res.kind;
  assign image_width   = out_res.image_width;
  assign image_height  = out_res.image_height;
  assign has_alpha     = out_res.has_alpha;
  assign red           = out_res.red;
  assign green         = out_res.green;
  assign blue          = out_res.blue;
  assign alpha         = out_res.alpha;
  assign repeat_count  = out_res.repeat_count;
  assign last_of_image = out_res.last_of_image;

endmodule
`default_nettype wire
